>>> design/audio_queue_rate_declick_macros.svh
// assertion macros shared by the audio queue controller modules
`ifndef AUDIO_QUEUE_RATE_DECLICK_MACROS_SVH
`define AUDIO_QUEUE_RATE_DECLICK_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AQRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define AQRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define AQRD_ASSERT(lbl, prop, msg)
`define AQRD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/aqrd_pkg.sv
// types, constants and codes of the audio queue controller
package aqrd_pkg;

    localparam int SLOT_COUNT    = 16;
    localparam int BUFFER_FRAMES = 800;
    localparam int FADE_LENGTH   = 96;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CMP_W  = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;

    localparam int FI_W     = 10;
    localparam int SAMPLE_W = 16;

    localparam int RAMP_LEN  = (BUFFER_FRAMES < FADE_LENGTH) ? BUFFER_FRAMES : FADE_LENGTH;
    localparam int COEF_W    = $clog2(RAMP_LEN + 1);
    localparam int MAG_W     = SAMPLE_W - 1 + COEF_W;
    localparam int PROD_W    = MAG_W + 1;
    localparam int DIV_SHIFT = MAG_W + $clog2(RAMP_LEN);
    localparam int RECIP_W   = MAG_W + 1;
    localparam int WIDE_W    = MAG_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << DIV_SHIFT) + RAMP_LEN - 1) / RAMP_LEN;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;

    typedef enum logic [2:0] {
        OP_COMMIT  = 3'd0,
        OP_PERIOD  = 3'd1,
        OP_FRAME   = 3'd2,
        OP_QUERY   = 3'd3,
        OP_RESTART = 3'd4,
        OP_STOP    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_RING = 2'd1,
        SRC_FADE = 2'd2
    } src_t;

    typedef enum logic [1:0] {
        RATE_NOMINAL = 2'd0,
        RATE_SLOW    = 2'd1,
        RATE_FAST    = 2'd2
    } rate_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HIGH_WATER   = 3'd0,
        CFG_HIGH_RELEASE = 3'd1,
        CFG_LOW_RELEASE  = 3'd2,
        CFG_LOW_WATER    = 3'd3,
        CFG_START_LEVEL  = 3'd4,
        CFG_MAX_QUEUED   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic       rejected;
        rate_t      rate_code;
        logic [3:0] write_slot;
        logic [3:0] play_slot;
        src_t       play_source;
        logic       start_playback;
        logic [3:0] occupancy;
        logic       can_write;
        logic       tail_capture;
    } step_res_t;

endpackage

>>> design/aqrd_ctrl.sv
// queue pointers, playback state, rate hysteresis, tail store and ramp coefficient
`include "audio_queue_rate_declick_macros.svh"

module aqrd_ctrl (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [aqrd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [aqrd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 step_en,
    input  logic [2:0]                           op,
    input  logic                                 turbo,
    input  logic [aqrd_pkg::FI_W-1:0]            frame_index,
    input  logic signed [aqrd_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [aqrd_pkg::SAMPLE_W-1:0] right_in,
    input  logic                                 tail_wr,
    input  logic signed [aqrd_pkg::SAMPLE_W-1:0] tail_left_in,
    input  logic signed [aqrd_pkg::SAMPLE_W-1:0] tail_right_in,
    output aqrd_pkg::step_res_t                  res,
    output logic signed [aqrd_pkg::SAMPLE_W-1:0] left_opnd,
    output logic signed [aqrd_pkg::SAMPLE_W-1:0] right_opnd,
    output logic [aqrd_pkg::COEF_W-1:0]          coef
);
    import aqrd_pkg::*;

    logic [4:0] high_water_reg, high_release_reg, low_release_reg, low_water_reg;
    logic [3:0] start_level_reg, max_queued_reg;

    logic [SLOT_W-1:0] wpos_reg, wpos_next, rpos_reg, rpos_next;
    logic              playing_reg, playing_next;
    logic              starved_reg, starved_next;
    logic              fade_in_reg, fade_in_next;
    rate_t             rate_reg, rate_next;
    src_t              kind_reg, kind_next;
    logic signed [SAMPLE_W-1:0] tail_left_reg, tail_right_reg;
    logic              tail_clear;

    logic [SLOT_W-1:0] occ, occ_n;
    logic [CMP_W-1:0]  occ_x, occ_nx;
    logic              ramp_zone;

    function automatic logic [SLOT_W-1:0] occ_of(input logic [SLOT_W-1:0] w,
                                                 input logic [SLOT_W-1:0] r);
        logic [SLOT_W:0] diff;
        diff = {1'b0, w} - {1'b0, r};
        if (w < r) begin
            diff = {1'b0, w} + (SLOT_W + 1)'(SLOT_COUNT) - {1'b0, r};
        end
        return diff[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
        return (p == SLOT_W'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        occ          = occ_of(wpos_reg, rpos_reg);
        occ_x        = CMP_W'(occ);
        wpos_next    = wpos_reg;
        rpos_next    = rpos_reg;
        playing_next = playing_reg;
        starved_next = starved_reg;
        fade_in_next = fade_in_reg;
        rate_next    = rate_reg;
        kind_next    = kind_reg;
        tail_clear   = 1'b0;
        res          = '0;
        left_opnd    = left_in;
        right_opnd   = right_in;
        coef         = '0;
        ramp_zone    = frame_index < FI_W'(RAMP_LEN);

        unique case (op)
            OP_COMMIT: begin
                if (occ_x >= CMP_W'(max_queued_reg) || occ == SLOT_W'(SLOT_COUNT - 1)) begin
                    res.rejected = 1'b1;
                end else begin
                    wpos_next = next_slot(wpos_reg);
                    if (!playing_reg && (occ_x + 1'b1) >= CMP_W'(start_level_reg)) begin
                        res.start_playback = 1'b1;
                        res.play_source    = SRC_RING;
                        res.play_slot      = 4'(rpos_reg);
                        rpos_next          = next_slot(rpos_reg);
                        playing_next       = 1'b1;
                        kind_next          = SRC_RING;
                        fade_in_next       = 1'b0;
                    end
                end
            end
            OP_PERIOD: begin
                if (playing_reg) begin
                    if (occ == '0) begin
                        starved_next    = 1'b1;
                        kind_next       = SRC_FADE;
                        res.play_source = SRC_FADE;
                    end else begin
                        fade_in_next    = starved_reg;
                        starved_next    = 1'b0;
                        kind_next       = SRC_RING;
                        res.play_source = SRC_RING;
                        res.play_slot   = 4'(rpos_reg);
                        rpos_next       = next_slot(rpos_reg);
                    end
                end
            end
            OP_FRAME: begin
                if (kind_reg == SRC_FADE) begin
                    left_opnd  = tail_left_reg;
                    right_opnd = tail_right_reg;
                    if (ramp_zone) begin
                        coef = COEF_W'(RAMP_LEN) - frame_index[COEF_W-1:0];
                    end
                end else if (kind_reg == SRC_RING) begin
                    if (fade_in_reg && ramp_zone) begin
                        coef = frame_index[COEF_W-1:0];
                    end else begin
                        coef = COEF_W'(RAMP_LEN);
                    end
                    res.tail_capture = 32'(frame_index) == 32'(BUFFER_FRAMES - 1);
                end
            end
            OP_QUERY: begin
                if (turbo) begin
                    rate_next = RATE_NOMINAL;
                end else begin
                    if (rate_reg == RATE_SLOW && occ_x <= CMP_W'(high_release_reg)) begin
                        rate_next = RATE_NOMINAL;
                    end else if (rate_reg == RATE_FAST
                                 && occ_x >= CMP_W'(low_release_reg)) begin
                        rate_next = RATE_NOMINAL;
                    end
                    if (occ_x > CMP_W'(high_water_reg)) begin
                        rate_next = RATE_SLOW;
                    end else if (occ_x < CMP_W'(low_water_reg)) begin
                        rate_next = RATE_FAST;
                    end
                end
            end
            OP_RESTART: begin
                wpos_next    = '0;
                rpos_next    = '0;
                playing_next = 1'b0;
                starved_next = 1'b0;
                fade_in_next = 1'b0;
                rate_next    = RATE_NOMINAL;
                kind_next    = SRC_NONE;
                tail_clear   = 1'b1;
            end
            OP_STOP: begin
                playing_next = 1'b0;
                kind_next    = SRC_NONE;
            end
            default: begin
            end
        endcase

        occ_n          = occ_of(wpos_next, rpos_next);
        occ_nx         = CMP_W'(occ_n);
        res.occupancy  = 4'(occ_n);
        res.can_write  = occ_nx < CMP_W'(max_queued_reg) && occ_n != SLOT_W'(SLOT_COUNT - 1);
        res.write_slot = 4'(wpos_next);
        res.rate_code  = rate_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_water_reg   <= 5'd8;
            high_release_reg <= 5'd6;
            low_release_reg  <= 5'd6;
            low_water_reg    <= 5'd4;
            start_level_reg  <= 4'd4;
            max_queued_reg   <= 4'd12;
            wpos_reg         <= '0;
            rpos_reg         <= '0;
            playing_reg      <= 1'b0;
            starved_reg      <= 1'b0;
            fade_in_reg      <= 1'b0;
            rate_reg         <= RATE_NOMINAL;
            kind_reg         <= SRC_NONE;
            tail_left_reg    <= '0;
            tail_right_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_HIGH_WATER:   high_water_reg   <= cfg_wdata;
                    CFG_HIGH_RELEASE: high_release_reg <= cfg_wdata;
                    CFG_LOW_RELEASE:  low_release_reg  <= cfg_wdata;
                    CFG_LOW_WATER:    low_water_reg    <= cfg_wdata;
                    CFG_START_LEVEL:  start_level_reg  <= cfg_wdata[3:0];
                    CFG_MAX_QUEUED:   max_queued_reg   <= cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
            if (step_en) begin
                wpos_reg    <= wpos_next;
                rpos_reg    <= rpos_next;
                playing_reg <= playing_next;
                starved_reg <= starved_next;
                fade_in_reg <= fade_in_next;
                rate_reg    <= rate_next;
                kind_reg    <= kind_next;
            end
            // a restart is younger than any frame still finishing, so it wins
            if (step_en && tail_clear) begin
                tail_left_reg  <= '0;
                tail_right_reg <= '0;
            end else if (tail_wr) begin
                tail_left_reg  <= tail_left_in;
                tail_right_reg <= tail_right_in;
            end
        end
    end

    `AQRD_ASSERT(a_stopped_no_kind, !playing_reg |-> kind_reg == SRC_NONE,
        "period kind set while playback is stopped")
    `AQRD_ASSERT(a_restart_clears, step_en && tail_clear |=> wpos_reg == '0 && rpos_reg == '0,
        "restart left ring pointers set")

endmodule

>>> design/aqrd_scale.sv
// one sample lane: product register, then exact divide by the ramp length
module aqrd_scale (
    input  logic                                 aclk,
    input  logic                                 load,
    input  logic signed [aqrd_pkg::SAMPLE_W-1:0] sample,
    input  logic [aqrd_pkg::COEF_W-1:0]          coef,
    output logic signed [aqrd_pkg::SAMPLE_W-1:0] result
);
    import aqrd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg;
    logic [PROD_W-1:0]        mag_full;
    logic [MAG_W-1:0]         mag;
    logic [WIDE_W-1:0]        wide;
    logic [SAMPLE_W-1:0]      quot;

    assign prod_next = PROD_W'(sample) * $signed(PROD_W'({1'b0, coef}));

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    // reciprocal multiply, exact for every magnitude the product can reach
    always_comb begin
        neg      = prod_reg[PROD_W-1];
        mag_full = neg ? -prod_reg : prod_reg;
        mag      = mag_full[MAG_W-1:0];
        wide     = WIDE_W'(mag) * WIDE_W'(RECIP_V);
        quot     = wide[DIV_SHIFT +: SAMPLE_W];
        result   = $signed(neg ? -quot : quot);
    end

endmodule

>>> design/audio_queue_rate_declick.sv
// each item passes the input, product and result registers in that order before its
// result is offered on m_tdata
// throughput: one item per cycle; a stalled result drops s_tready once the input and
// product stages behind it are full
// the ramp divide is a reciprocal multiply in the stage after the product register
// reset: aresetn synchronous active low; clears pipeline valids, ring state and tail
`include "audio_queue_rate_declick_macros.svh"

module audio_queue_rate_declick (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [aqrd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [aqrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // turbo, frame_index, left_in, right_in, zero pad
    input  logic [aqrd_pkg::S_TDATA_W-1:0]      s_tdata,
    // op
    input  logic [aqrd_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // can_write, occupancy, start_playback, play_source, play_slot, write_slot,
    // left_out, right_out, rate_code, rejected, zero pad
    output logic [aqrd_pkg::M_TDATA_W-1:0]      m_tdata
);
    import aqrd_pkg::*;

    logic                       a_valid_reg, b_valid_reg, o_valid_reg;
    logic [S_TDATA_W-1:0]       a_data_reg;
    logic [S_TUSER_W-1:0]       a_op_reg;
    step_res_t                  b_res_reg, a_res;
    logic [M_TDATA_W-1:0]       o_data_reg, o_data_next;
    logic                       en_o, en_b, en_a, step_en, tail_wr;
    logic signed [SAMPLE_W-1:0] left_opnd, right_opnd, left_q, right_q;
    logic [COEF_W-1:0]          coef;

    assign en_o     = !o_valid_reg || m_tready;
    assign en_b     = !b_valid_reg || en_o;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;
    assign step_en  = a_valid_reg && en_b;
    assign tail_wr  = b_valid_reg && en_o && b_res_reg.tail_capture;
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

    aqrd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .step_en       (step_en),
        .op            (a_op_reg),
        .turbo         (a_data_reg[0]),
        .frame_index   (a_data_reg[10:1]),
        .left_in       ($signed(a_data_reg[26:11])),
        .right_in      ($signed(a_data_reg[42:27])),
        .tail_wr       (tail_wr),
        .tail_left_in  (left_q),
        .tail_right_in (right_q),
        .res           (a_res),
        .left_opnd     (left_opnd),
        .right_opnd    (right_opnd),
        .coef          (coef)
    );

    aqrd_scale u_scale_left (
        .aclk   (aclk),
        .load   (en_b),
        .sample (left_opnd),
        .coef   (coef),
        .result (left_q)
    );

    aqrd_scale u_scale_right (
        .aclk   (aclk),
        .load   (en_b),
        .sample (right_opnd),
        .coef   (coef),
        .result (right_q)
    );

    assign o_data_next = {5'b0, b_res_reg.rejected, b_res_reg.rate_code, right_q, left_q,
                          b_res_reg.write_slot, b_res_reg.play_slot, b_res_reg.play_source,
                          b_res_reg.start_playback, b_res_reg.occupancy,
                          b_res_reg.can_write};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (en_a) begin
                a_valid_reg <= s_tvalid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_o) begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_data_reg <= s_tdata;
            a_op_reg   <= s_tuser;
        end
        if (en_b) begin
            b_res_reg <= a_res;
        end
        if (en_o) begin
            o_data_reg <= o_data_next;
        end
    end

    `AQRD_ASSERT(a_result_kept, o_valid_reg && !m_tready |=> o_valid_reg,
        "pending result dropped while stalled")
    `AQRD_ASSERT_ALWAYS(a_ready_when_empty, !o_valid_reg |-> s_tready,
        "input blocked while result register is empty")
    `AQRD_ASSERT(a_reject_no_dispatch,
        m_tvalid && m_tdata[50] |-> m_tdata[7:6] == SRC_NONE,
        "refused commit dispatched a buffer")
    `AQRD_ASSERT(a_start_is_ring,
        m_tvalid && m_tdata[5] |-> m_tdata[7:6] == SRC_RING,
        "playback start without ring dispatch")

endmodule

>>> dv/tb_audio_queue_rate_declick.sv
// self-checking testbench for the audio queue controller with rate hysteresis and declick ramps
`timescale 1ns / 100ps

module tb_audio_queue_rate_declick;
    import aqrd_pkg::*;

    localparam logic [2:0] OP_NOP_LO = 3'd6;
    localparam logic [2:0] OP_NOP_HI = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 186;

    typedef struct packed {
        logic               can_write;
        logic [3:0]         occupancy;
        logic               start_playback;
        src_t               play_source;
        logic [3:0]         play_slot;
        logic [3:0]         write_slot;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        rate_t              rate_code;
        logic               rejected;
    } step_out_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        turbo;
        logic [9:0]  fi;
        logic [15:0] left_in;
        logic [15:0] right_in;
        logic        typed;
        step_out_t   want;
    } script_row_t;

    localparam step_out_t QUIET_OUT = '{1'b1, 4'd0, 1'b0, SRC_NONE, 4'd0, 4'd0,
                                        16'sd0, 16'sd0, RATE_NOMINAL, 1'b0};
    localparam step_out_t QUIET_FAST = '{1'b1, 4'd0, 1'b0, SRC_NONE, 4'd0, 4'd0,
                                         16'sd0, 16'sd0, RATE_FAST, 1'b0};

    localparam int SCRIPT_LEN = 26;
    localparam script_row_t PLAYBACK_SCRIPT [SCRIPT_LEN] = '{
        '{OP_FRAME,   1'b0, 10'd0,    16'h7fff, 16'h8000, 1'b1, QUIET_OUT},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b1, QUIET_OUT},
        '{OP_QUERY,   1'b0, 10'd0,    16'h0000, 16'h0000, 1'b1, QUIET_FAST},
        '{OP_COMMIT,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_COMMIT,  1'b1, 10'd1023, 16'hffff, 16'hffff, 1'b0, '0},
        '{OP_COMMIT,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_COMMIT,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_FRAME,   1'b0, 10'd799,  16'h7fff, 16'h8000, 1'b0, '0},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_FRAME,   1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_FRAME,   1'b0, 10'd95,   16'h1111, 16'h2222, 1'b0, '0},
        '{OP_FRAME,   1'b0, 10'd1023, 16'h3333, 16'h4444, 1'b0, '0},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_COMMIT,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_FRAME,   1'b0, 10'd48,   16'h8000, 16'h7fff, 1'b0, '0},
        '{OP_FRAME,   1'b0, 10'd1023, 16'h04d2, 16'hffff, 1'b0, '0},
        '{OP_QUERY,   1'b1, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_STOP,    1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_PERIOD,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b0, '0},
        '{OP_RESTART, 1'b0, 10'd0,    16'h0000, 16'h0000, 1'b1, QUIET_OUT},
        '{OP_NOP_LO,  1'b0, 10'd0,    16'h0000, 16'h0000, 1'b1, QUIET_OUT},
        '{OP_NOP_HI,  1'b1, 10'd1023, 16'hffff, 16'hffff, 1'b1, QUIET_OUT}
    };

    // high_water, high_release, low_release, low_water, start_level, max_queued
    localparam logic [4:0] CFG_SETS [PHASES][6] = '{
        '{5'd8,  5'd6,  5'd6,  5'd4,  5'd4,  5'd12},
        '{5'd16, 5'd0,  5'd16, 5'd0,  5'd1,  5'd1},
        '{5'd0,  5'd0,  5'd0,  5'd16, 5'd15, 5'd15},
        '{5'd31, 5'd31, 5'd31, 5'd31, 5'd15, 5'd15},
        '{5'd10, 5'd7,  5'd5,  5'd3,  5'd2,  5'd14},
        '{5'd12, 5'd2,  5'd9,  5'd5,  5'd0,  5'd8},
        '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    audio_queue_rate_declick dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int errors = 0;
    int cycles = 0;
    step_out_t expected_steps [$];

    // ring controller state and settings as seen from outside
    logic [4:0] hw_thr = 5'd8, hr_thr = 5'd6, lr_thr = 5'd6, lw_thr = 5'd4;
    logic [3:0] start_lvl = 4'd4, max_q = 4'd12;
    logic [3:0] wr_pos = '0, rd_pos = '0;
    logic       playing = 1'b0, starved = 1'b0, fade_in = 1'b0;
    rate_t      rate_st = RATE_NOMINAL;
    src_t       kind = SRC_NONE;
    int         tail_l = 0, tail_r = 0;

    function automatic void store_setting(cfg_idx_t idx, logic [4:0] v);
        case (idx)
            CFG_HIGH_WATER:   hw_thr = v;
            CFG_HIGH_RELEASE: hr_thr = v;
            CFG_LOW_RELEASE:  lr_thr = v;
            CFG_LOW_WATER:    lw_thr = v;
            CFG_START_LEVEL:  start_lvl = v[3:0];
            CFG_MAX_QUEUED:   max_q = v[3:0];
            default: ;
        endcase
    endfunction

    function automatic step_out_t predict_queue_step(logic [2:0] op, logic turbo,
            logic [9:0] fi, logic signed [15:0] l_in, logic signed [15:0] r_in);
        step_out_t o;
        logic [3:0] occ;
        int i, n, lo, ro;
        o = '0;
        lo = 0;
        ro = 0;
        n = RAMP_LEN;
        i = fi;
        occ = wr_pos - rd_pos;
        case (op)
            OP_COMMIT: begin
                if (occ >= max_q || occ == 4'd15) begin
                    o.rejected = 1'b1;
                end else begin
                    wr_pos = wr_pos + 4'd1;
                    occ = wr_pos - rd_pos;
                    if (!playing && occ >= start_lvl) begin
                        o.start_playback = 1'b1;
                        o.play_source = SRC_RING;
                        o.play_slot = rd_pos;
                        rd_pos = rd_pos + 4'd1;
                        playing = 1'b1;
                        kind = SRC_RING;
                        fade_in = 1'b0;
                    end
                end
            end
            OP_PERIOD: begin
                if (playing) begin
                    if (occ == 4'd0) begin
                        starved = 1'b1;
                        kind = SRC_FADE;
                        o.play_source = SRC_FADE;
                    end else begin
                        fade_in = starved;
                        starved = 1'b0;
                        kind = SRC_RING;
                        o.play_source = SRC_RING;
                        o.play_slot = rd_pos;
                        rd_pos = rd_pos + 4'd1;
                    end
                end
            end
            OP_FRAME: begin
                if (kind == SRC_FADE) begin
                    if (i < n) begin
                        lo = (tail_l * (n - i)) / n;
                        ro = (tail_r * (n - i)) / n;
                    end
                end else if (kind == SRC_RING) begin
                    if (fade_in && i < n) begin
                        lo = (int'(l_in) * i) / n;
                        ro = (int'(r_in) * i) / n;
                    end else begin
                        lo = l_in;
                        ro = r_in;
                    end
                    if (fi == 10'(BUFFER_FRAMES - 1)) begin
                        tail_l = lo;
                        tail_r = ro;
                    end
                end
            end
            OP_QUERY: begin
                if (turbo) begin
                    rate_st = RATE_NOMINAL;
                end else begin
                    if (rate_st == RATE_SLOW && occ <= hr_thr)
                        rate_st = RATE_NOMINAL;
                    else if (rate_st == RATE_FAST && occ >= lr_thr)
                        rate_st = RATE_NOMINAL;
                    if (occ > hw_thr)
                        rate_st = RATE_SLOW;
                    else if (occ < lw_thr)
                        rate_st = RATE_FAST;
                end
            end
            OP_RESTART: begin
                wr_pos = '0;
                rd_pos = '0;
                playing = 1'b0;
                starved = 1'b0;
                fade_in = 1'b0;
                rate_st = RATE_NOMINAL;
                kind = SRC_NONE;
                tail_l = 0;
                tail_r = 0;
            end
            OP_STOP: begin
                playing = 1'b0;
                kind = SRC_NONE;
            end
            default: ;
        endcase
        occ = wr_pos - rd_pos;
        o.can_write = (occ < max_q) && (occ != 4'd15);
        o.occupancy = occ;
        o.write_slot = wr_pos;
        o.left_out = 16'(lo);
        o.right_out = 16'(ro);
        o.rate_code = rate_st;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    task automatic check_step(logic [M_TDATA_W-1:0] d);
        step_out_t got, want;
        got.can_write = d[0];
        got.occupancy = d[4:1];
        got.start_playback = d[5];
        got.play_source = src_t'(d[7:6]);
        got.play_slot = d[11:8];
        got.write_slot = d[15:12];
        got.left_out = d[31:16];
        got.right_out = d[47:32];
        got.rate_code = rate_t'(d[49:48]);
        got.rejected = d[50];
        if (expected_steps.size() == 0) begin
            report_mismatch("transfer with no expected step", 1, 0);
            return;
        end
        want = expected_steps.pop_front();
        if (got.can_write !== want.can_write)
            report_mismatch("can_write", got.can_write, want.can_write);
        if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", got.occupancy, want.occupancy);
        if (got.start_playback !== want.start_playback)
            report_mismatch("start_playback", got.start_playback, want.start_playback);
        if (got.play_source !== want.play_source)
            report_mismatch("play_source", got.play_source, want.play_source);
        if (got.play_slot !== want.play_slot)
            report_mismatch("play_slot", got.play_slot, want.play_slot);
        if (got.write_slot !== want.write_slot)
            report_mismatch("write_slot", got.write_slot, want.write_slot);
        if (got.left_out !== want.left_out)
            report_mismatch("left_out", $signed(got.left_out), $signed(want.left_out));
        if (got.right_out !== want.right_out)
            report_mismatch("right_out", $signed(got.right_out), $signed(want.right_out));
        if (got.rate_code !== want.rate_code)
            report_mismatch("rate_code", got.rate_code, want.rate_code);
        if (got.rejected !== want.rejected)
            report_mismatch("rejected", got.rejected, want.rejected);
    endtask

    task automatic send_step(logic [2:0] op, logic turbo, logic [9:0] fi,
            logic [15:0] l_in, logic [15:0] r_in, logic typed, step_out_t typed_want);
        step_out_t want;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b0, r_in, l_in, fi, turbo};
        do @(posedge aclk); while (!s_tready);
        want = predict_queue_step(op, turbo, fi, l_in, r_in);
        expected_steps.push_back(typed ? typed_want : want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(int p);
        for (int j = 0; j < 6; j++) begin
            cfg_we <= 1'b1;
            cfg_addr <= CFG_ADDR_W'(j);
            cfg_wdata <= CFG_SETS[p][j];
            @(posedge aclk);
            store_setting(cfg_idx_t'(j), CFG_SETS[p][j]);
        end
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_step(m_tdata);
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("audio_queue_rate_declick regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] pick_sample();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 16'h7fff : 16'h8000;
        return 16'($urandom);
    endfunction

    initial begin
        int pick;
        logic [2:0] op;
        logic [9:0] fi;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle_pct = 21;
        rcv_idle_pct = 81;
        foreach (PLAYBACK_SCRIPT[k])
            send_step(PLAYBACK_SCRIPT[k].op, PLAYBACK_SCRIPT[k].turbo, PLAYBACK_SCRIPT[k].fi,
                      PLAYBACK_SCRIPT[k].left_in, PLAYBACK_SCRIPT[k].right_in,
                      PLAYBACK_SCRIPT[k].typed, PLAYBACK_SCRIPT[k].want);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                snd_idle_pct = 21;
                rcv_idle_pct = 81;
            end else if (p < 4) begin
                snd_idle_pct = 81;
                rcv_idle_pct = 21;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            drain_results();
            write_settings(p);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(99);
                if (pick < 28)      op = OP_COMMIT;
                else if (pick < 42) op = OP_PERIOD;
                else if (pick < 78) op = OP_FRAME;
                else if (pick < 88) op = OP_QUERY;
                else if (pick < 92) op = OP_STOP;
                else if (pick < 94) op = OP_RESTART;
                else if (pick < 97) op = OP_NOP_LO;
                else                op = OP_NOP_HI;
                pick = $urandom_range(9);
                if (pick < 3)       fi = 10'($urandom_range(RAMP_LEN - 1));
                else if (pick == 3) fi = 10'(BUFFER_FRAMES - 1);
                else if (pick == 4) fi = 10'($urandom_range(1023, BUFFER_FRAMES));
                else                fi = 10'($urandom_range(BUFFER_FRAMES - 1));
                send_step(op, 1'($urandom_range(1)), fi, pick_sample(), pick_sample(),
                          1'b0, '0);
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("audio_queue_rate_declick regression: pass");
        else
            $display("audio_queue_rate_declick regression: fail");
        $finish;
    end

endmodule

>>> audio_queue_rate_declick.f
+incdir+design
design/aqrd_pkg.sv
design/aqrd_ctrl.sv
design/aqrd_scale.sv
design/audio_queue_rate_declick.sv
dv/tb_audio_queue_rate_declick.sv
